// ----- src/rmvo_pkg.sv -----
// Package with shared types, codes and constants of the running statistics block.
`default_nettype none
package rmvo_pkg;

	localparam int METRICS = 64;
	localparam int IDX_W = 6;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;
	localparam logic [31:0] SD_MAX = 32'h7FFF_FFFF;
	localparam logic [63:0] SAT64 = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef enum logic [1:0] {
		ACT_ADD   = 2'd0,
		ACT_CHECK = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef struct packed {
		logic [1:0]         action;
		logic [5:0]         metric_index;
		logic signed [31:0] sample_value;
		logic               value_present;
	} request_t;

	typedef struct packed {
		logic signed [31:0] mean_out;
		logic [30:0]        stddev_out;
		logic [15:0]        count_out;
		logic               warn;
		logic               undefined;
	} result_t;

endpackage
`default_nettype wire

// ----- src/running_mean_variance_outlier.sv -----
// Top level: per-metric running mean and variance table with outlier check.
// Usage: drive request and pulse start while busy is low; the request is taken
// at that clock edge and busy rises on the next cycle. Each request gives one
// result, shown on result for exactly one cycle while done is high.
// Actions: add a sample (Welford update), check a value against the entry's
// mean and sample standard deviation, or clear the entry.
// Clear, an unused action, a first sample and an add to a full entry
// finish after the read and decode states; a check with at most one sample
// also passes the warn state. An add with history runs the serial divider,
// the mean update and four passes through the shared 32 by 32 multiplier.
// A check with two or more samples runs the divider for the variance and
// then the square root. The block takes one request at a time.
// The threshold register is written with cfg_we and cfg_wdata; the user
// must write it only while idle, as the block itself does not enforce this.
// Reset empties every entry (per-entry valid flags) and sets the threshold
// to 2; no clearing pass is needed. The receiver cannot stall results.
`default_nettype none
module running_mean_variance_outlier (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire rmvo_pkg::request_t request,
	output logic                   done,
	output rmvo_pkg::result_t      result,
	input  wire logic              cfg_we,
	input  wire logic [3:0]        cfg_wdata
);

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_DEC, S_DIV, S_MEAN, S_MULD, S_MULLO, S_MULHI, S_MULE,
		S_ACC, S_VDIV, S_SQRT, S_WARN
	} state_t;

	state_t state_q;

	logic [31:0] mean_mem [rmvo_pkg::METRICS];
	logic [63:0] ssd_mem [rmvo_pkg::METRICS];
	logic [15:0] cnt_mem [rmvo_pkg::METRICS];
	logic [rmvo_pkg::METRICS-1:0] valid_q;

	logic [3:0]         z_q;
	logic [1:0]         act_q;
	logic [5:0]         idx_q;
	logic signed [31:0] x_q;
	logic               pres_q;
	logic [31:0]        mean_rd_q;
	logic [63:0]        ssd_rd_q;
	logic [15:0]        cnt_rd_q;
	logic               neg_q;
	logic signed [32:0] d_q;
	logic [31:0]        mnew_q;
	logic [63:0]        sq_q;
	logic [47:0]        plo_q;
	logic [63:0]        acc_q;
	logic [30:0]        sd_q;
	logic               done_q;
	rmvo_pkg::result_t  res_q;

	logic [rmvo_pkg::IDX_W-1:0] addr;
	logic        idx_ok;
	logic        ent_valid;
	logic [15:0] cnt_eff;
	logic [31:0] mean_eff;
	rmvo_pkg::result_t dec_res;
	logic        chk_warn;
	logic signed [32:0] diff;
	logic [32:0] diff_mag;
	logic [32:0] d_mag;
	logic signed [32:0] err;
	logic [32:0] err_mag;
	logic signed [32:0] chk;
	logic [32:0] chk_mag;
	logic [34:0] limit;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	logic [79:0] scaled;
	logic [64:0] acc_sum;
	logic [64:0] ssd_sum;
	logic        wr_en;
	logic [31:0] wr_mean;
	logic [63:0] wr_ssd;
	logic [15:0] wr_cnt;
	logic        div_start;
	logic [63:0] div_dividend;
	logic [15:0] div_divisor;
	logic [63:0] div_quo;
	logic        div_done;
	logic        sq_start;
	logic [31:0] sq_root;
	logic        sq_done;

	assign addr = idx_q[rmvo_pkg::IDX_W-1:0];
	assign idx_ok = {1'b0, idx_q} < 7'(rmvo_pkg::METRICS);
	assign ent_valid = idx_ok && valid_q[addr];
	assign cnt_eff = ent_valid ? cnt_rd_q : 16'd0;
	assign mean_eff = (cnt_eff != 16'd0) ? mean_rd_q : 32'd0;

	always_comb begin
		dec_res = '0;
		dec_res.mean_out = mean_eff;
		dec_res.count_out = cnt_eff;
		if (idx_ok && act_q == rmvo_pkg::ACT_ADD && cnt_eff == 16'd0) begin
			dec_res.mean_out = x_q;
			dec_res.count_out = 16'd1;
		end else if (idx_ok && act_q == rmvo_pkg::ACT_CLEAR) begin
			dec_res.mean_out = '0;
			dec_res.count_out = '0;
		end
	end

	assign diff = 33'(x_q) - 33'($signed(mean_rd_q));
	assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
	assign d_mag = d_q[32] ? 33'(-d_q) : 33'(d_q);
	assign err = 33'(x_q) - 33'($signed(mnew_q));
	assign err_mag = err[32] ? 33'(-err) : 33'(err);
	assign chk = 33'(x_q) - 33'($signed(mean_eff));
	assign chk_mag = chk[32] ? 33'(-chk) : 33'(chk);
	assign limit = 35'(z_q) * 35'(sd_q);
	assign chk_warn = pres_q && (cnt_eff != 16'd0) && ({2'b00, chk_mag} > limit);

	always_comb begin
		mul_a = err_mag[31:0];
		mul_b = err_mag[31:0];
		case (state_q)
			S_MULD: begin
				mul_a = d_mag[31:0];
				mul_b = d_mag[31:0];
			end
			S_MULLO: begin
				mul_a = {16'd0, cnt_rd_q};
				mul_b = sq_q[31:0];
			end
			S_MULHI: begin
				mul_a = {16'd0, cnt_rd_q};
				mul_b = sq_q[63:32];
			end
			default: begin
				mul_a = err_mag[31:0];
				mul_b = err_mag[31:0];
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;
	assign scaled = {mul_p[47:0], 32'd0} + {32'd0, plo_q};
	assign acc_sum = {1'b0, acc_q} + {1'b0, mul_p};
	assign ssd_sum = {1'b0, ssd_rd_q} + {1'b0, acc_q};

	assign wr_en = idx_ok && ((state_q == S_ACC) || (state_q == S_DEC
		&& act_q == rmvo_pkg::ACT_ADD && cnt_eff == 16'd0));
	assign wr_mean = (state_q == S_ACC) ? mnew_q : x_q;
	assign wr_ssd = (state_q == S_ACC) ? (ssd_sum[64] ? rmvo_pkg::SAT64 : ssd_sum[63:0])
		: 64'd0;
	assign wr_cnt = (state_q == S_ACC) ? cnt_rd_q + 16'd1 : 16'd1;

	assign div_start = (state_q == S_DEC) && ((act_q == rmvo_pkg::ACT_ADD
		&& cnt_eff != 16'd0 && cnt_eff != rmvo_pkg::COUNT_MAX)
		|| (act_q == rmvo_pkg::ACT_CHECK && cnt_eff > 16'd1));
	assign div_dividend = (act_q == rmvo_pkg::ACT_ADD) ? {31'd0, diff_mag} : ssd_rd_q;
	assign div_divisor = (act_q == rmvo_pkg::ACT_ADD) ? cnt_rd_q + 16'd1
		: cnt_rd_q - 16'd1;
	assign sq_start = (state_q == S_VDIV) && div_done;

	rmvo_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quo),
		.done     (div_done)
	);

	rmvo_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (div_quo),
		.root     (sq_root),
		.done     (sq_done)
	);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mean_mem[addr] <= wr_mean;
			ssd_mem[addr] <= wr_ssd;
			cnt_mem[addr] <= wr_cnt;
		end
		if (state_q == S_RD) begin
			mean_rd_q <= mean_mem[addr];
			ssd_rd_q <= ssd_mem[addr];
			cnt_rd_q <= cnt_mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			act_q <= request.action;
			idx_q <= request.metric_index;
			x_q <= request.sample_value;
			pres_q <= request.value_present;
		end
		case (state_q)
			S_DEC: begin
				neg_q <= diff[32];
				sd_q <= '0;
			end
			S_DIV: d_q <= neg_q ? 33'(-$signed(div_quo[32:0])) : $signed(div_quo[32:0]);
			S_MEAN: mnew_q <= 32'(33'($signed(mean_rd_q)) + d_q);
			S_MULD: sq_q <= mul_p;
			S_MULLO: plo_q <= mul_p[47:0];
			S_MULHI: acc_q <= (scaled[79:64] != 16'd0) ? rmvo_pkg::SAT64 : scaled[63:0];
			S_MULE: acc_q <= acc_sum[64] ? rmvo_pkg::SAT64 : acc_sum[63:0];
			S_SQRT: sd_q <= (sq_root > rmvo_pkg::SD_MAX) ? rmvo_pkg::SD_MAX[30:0]
				: sq_root[30:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			z_q <= 4'd2;
			done_q <= 1'b0;
			res_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				z_q <= cfg_wdata;
			end
			if (wr_en) begin
				valid_q[addr] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_DEC;
				S_DEC: begin
					res_q <= dec_res;
					case (act_q)
						rmvo_pkg::ACT_ADD: begin
							if (div_start) begin
								state_q <= S_DIV;
							end else begin
								done_q <= 1'b1;
								state_q <= S_IDLE;
							end
						end
						rmvo_pkg::ACT_CHECK: begin
							if (div_start) begin
								state_q <= S_VDIV;
							end else begin
								state_q <= S_WARN;
							end
						end
						rmvo_pkg::ACT_CLEAR: begin
							if (idx_ok) begin
								valid_q[addr] <= 1'b0;
							end
							done_q <= 1'b1;
							state_q <= S_IDLE;
						end
						default: begin
							done_q <= 1'b1;
							state_q <= S_IDLE;
						end
					endcase
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_MEAN;
					end
				end
				S_MEAN: state_q <= S_MULD;
				S_MULD: state_q <= S_MULLO;
				S_MULLO: state_q <= S_MULHI;
				S_MULHI: state_q <= S_MULE;
				S_MULE: state_q <= S_ACC;
				S_ACC: begin
					res_q <= {mnew_q, 31'd0, wr_cnt, 1'b0, 1'b0};
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_VDIV: begin
					if (div_done) begin
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (sq_done) begin
						state_q <= S_WARN;
					end
				end
				S_WARN: begin
					res_q <= {res_q.mean_out, sd_q, res_q.count_out, chk_warn, !pres_q};
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign result = res_q;

	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("Result strobe raised while a request is still in progress.");

	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("Accepted request did not make the block busy.");

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.warn && result.undefined))
		else $error("A check reported both a warning and an undefined value.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.stddev_out != 31'd0) |-> (act_q == rmvo_pkg::ACT_CHECK))
		else $error("A non-zero deviation was reported for a request other than a check.");

endmodule
`default_nettype wire

// ----- src/rmvo_div.sv -----
// Restoring divider of a 64-bit dividend by a 16-bit divisor, one quotient bit per cycle.
`default_nettype none
module rmvo_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [15:0] divisor,
	output logic [63:0]      quotient,
	output logic             done
);

	logic [63:0] quo_q;
	logic [15:0] rem_q;
	logic [15:0] div_q;
	logic [5:0]  step_q;
	logic        run_q;
	logic        done_q;
	logic [16:0] shifted;
	logic        fits;

	assign shifted = {rem_q, quo_q[63]};
	assign fits = shifted >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 6'd1;
				if (step_q == 6'd63) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			if (fits) begin
				rem_q <= 16'(shifted - {1'b0, div_q});
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted[15:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign done = done_q;

endmodule
`default_nettype wire

// ----- src/rmvo_sqrt.sv -----
// Digit-by-digit floor square root of a 64-bit value, one root bit per cycle.
`default_nettype none
module rmvo_sqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] radicand,
	output logic [31:0]      root,
	output logic             done
);

	logic [63:0] rad_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [4:0]  step_q;
	logic        run_q;
	logic        done_q;
	logic [35:0] shifted;
	logic [35:0] trial;

	assign shifted = {rem_q, rad_q[63:62]};
	assign trial = {2'b00, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 5'd1;
				if (step_q == 5'd31) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q <= {rad_q[61:0], 2'b00};
			if (shifted >= trial) begin
				rem_q <= 34'(shifted - trial);
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted[33:0];
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule
`default_nettype wire

// ----- bench/running_mean_variance_outlier_test.sv -----
// Self-checking bench for the running mean, variance and outlier check block.
`default_nettype none
module running_mean_variance_outlier_test;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 120;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	rmvo_pkg::request_t request = '0;
	logic done;
	rmvo_pkg::result_t result;
	logic cfg_we = 1'b0;
	logic [3:0] cfg_wdata = 4'd0;

	logic [15:0] stat_count [rmvo_pkg::METRICS];
	logic signed [31:0] stat_mean [rmvo_pkg::METRICS];
	logic [63:0] stat_ssd [rmvo_pkg::METRICS];
	logic [3:0] threshold;

	rmvo_pkg::result_t expected_results [$];
	int errors = 0;
	int requests_sent = 0;
	int results_seen = 0;
	int warn_seen = 0;
	int idle_cycles = 0;
	bit idling_on = 1'b1;

	running_mean_variance_outlier u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #2 clk = ~clk;

	function automatic logic [63:0] sat_add64(logic [63:0] a, logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? rmvo_pkg::SAT64 : s[63:0];
	endfunction

	function automatic logic [63:0] floor_sqrt64(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] abs_diff(logic signed [63:0] v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic rmvo_pkg::result_t predict_stats(rmvo_pkg::request_t req);
		rmvo_pkg::result_t res;
		int unsigned i;
		logic [15:0] c;
		logic signed [63:0] x;
		logic signed [63:0] m;
		logic signed [63:0] d;
		logic [63:0] ad;
		logic [127:0] prod;
		logic [63:0] acc;
		logic [63:0] sd;
		logic [63:0] dev;
		i = req.metric_index;
		x = req.sample_value;
		res = '0;
		sd = 0;
		c = stat_count[i];
		if (req.action == rmvo_pkg::ACT_ADD) begin
			if (c == 0) begin
				stat_count[i] = 16'd1;
				stat_mean[i] = req.sample_value;
				stat_ssd[i] = 0;
			end else if (c != rmvo_pkg::COUNT_MAX) begin
				m = stat_mean[i];
				d = (x - m) / $signed({47'd0, c + 17'd1});
				m = m + d;
				ad = abs_diff(d);
				prod = c * (ad * ad);
				acc = (prod[127:64] != 0) ? rmvo_pkg::SAT64 : prod[63:0];
				ad = abs_diff(x - m);
				acc = sat_add64(acc, ad * ad);
				stat_ssd[i] = sat_add64(stat_ssd[i], acc);
				stat_mean[i] = m[31:0];
				stat_count[i] = c + 16'd1;
			end
		end else if (req.action == rmvo_pkg::ACT_CLEAR) begin
			stat_count[i] = 0;
			stat_mean[i] = 0;
			stat_ssd[i] = 0;
		end
		res.count_out = stat_count[i];
		res.mean_out = (stat_count[i] != 0) ? stat_mean[i] : 32'sd0;
		if (req.action == rmvo_pkg::ACT_CHECK) begin
			if (stat_count[i] > 1) begin
				sd = floor_sqrt64(stat_ssd[i] / (stat_count[i] - 64'd1));
				if (sd > rmvo_pkg::SD_MAX)
					sd = rmvo_pkg::SD_MAX;
			end
			if (!req.value_present) begin
				res.undefined = 1'b1;
			end else if (stat_count[i] != 0) begin
				dev = abs_diff(x - $signed({{32{res.mean_out[31]}}, res.mean_out}));
				res.warn = dev > threshold * sd;
			end
		end
		res.stddev_out = sd[30:0];
		return res;
	endfunction

	task automatic idle_gap();
		int n;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 14);
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_request(logic [1:0] act, logic [5:0] idx, logic [31:0] val,
			logic present);
		rmvo_pkg::request_t req;
		req.action = act;
		req.metric_index = idx;
		req.sample_value = val;
		req.value_present = present;
		idle_gap();
		start <= 1'b1;
		request <= req;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		expected_results.push_back(predict_stats(req));
		requests_sent++;
		start <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_threshold(logic [3:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		threshold = value;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				$display("%0t unexpected result %p", $time, result);
				errors++;
			end else begin
				if (expected_results[0].warn)
					warn_seen++;
				if (result !== expected_results[0]) begin
					$display("%0t mismatch expected %p actual %p", $time,
						expected_results[0], result);
					errors++;
				end
				void'(expected_results.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic test_directed();
		send_request(rmvo_pkg::ACT_CHECK, 6'd0, 32'd5, 1'b1);
		send_request(rmvo_pkg::ACT_CHECK, 6'd63, 32'd5, 1'b0);
		send_request(rmvo_pkg::ACT_ADD, 6'd0, 32'h7FFF_FFFF, 1'b0);
		send_request(rmvo_pkg::ACT_CHECK, 6'd0, 32'h8000_0000, 1'b1);
		send_request(rmvo_pkg::ACT_ADD, 6'd0, 32'h8000_0000, 1'b1);
		send_request(rmvo_pkg::ACT_ADD, 6'd0, 32'h7FFF_FFFF, 1'b1);
		send_request(rmvo_pkg::ACT_CHECK, 6'd0, 32'h8000_0000, 1'b1);
		send_request(rmvo_pkg::ACT_CHECK, 6'd0, 32'd0, 1'b0);
		send_request(rmvo_pkg::ACT_NONE, 6'd0, 32'hFFFF_FFFF, 1'b1);
		send_request(rmvo_pkg::ACT_CLEAR, 6'd0, 32'd0, 1'b0);
		send_request(rmvo_pkg::ACT_CHECK, 6'd0, 32'd1, 1'b1);
		send_request(rmvo_pkg::ACT_ADD, 6'd63, 32'h0001_0000, 1'b0);
		send_request(rmvo_pkg::ACT_ADD, 6'd63, 32'h0001_0000, 1'b0);
		send_request(rmvo_pkg::ACT_CHECK, 6'd63, 32'h0001_0000, 1'b1);
		send_request(rmvo_pkg::ACT_CHECK, 6'd63, 32'h0001_0001, 1'b1);
	endtask

	task automatic test_random(int items);
		logic [31:0] v;
		logic [5:0] idx;
		int sel;
		for (int k = 0; k < items; k++) begin
			idx = 6'($urandom_range(0, 7));
			if ($urandom_range(0, 9) == 0)
				idx = 6'($urandom);
			sel = $urandom_range(0, 99);
			case ($urandom_range(0, 3))
				0: v = $urandom;
				1: v = 32'h0010_0000 + $urandom_range(0, 32'h0004_0000);
				2: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
				default: v = $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
			endcase
			if (sel < 55)
				send_request(rmvo_pkg::ACT_ADD, idx, v, 1'($urandom));
			else if (sel < 88)
				send_request(rmvo_pkg::ACT_CHECK, idx, v, $urandom_range(0, 5) != 0);
			else if (sel < 95)
				send_request(rmvo_pkg::ACT_CLEAR, idx, v, 1'($urandom));
			else
				send_request(rmvo_pkg::ACT_NONE, idx, v, 1'($urandom));
		end
	endtask

	initial begin
		threshold = 4'd2;
		for (int i = 0; i < rmvo_pkg::METRICS; i++) begin
			stat_count[i] = 0;
			stat_mean[i] = 0;
			stat_ssd[i] = 0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		write_threshold(4'd15);
		send_request(rmvo_pkg::ACT_CHECK, 6'd63, 32'h0001_0001, 1'b1);
		write_threshold(4'd1);
		test_random(250);
		write_threshold(4'd15);
		test_random(200);
		write_threshold(4'd3);
		test_random(200);
		idling_on = 1'b0;
		write_threshold(4'd2);
		test_random(150);
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d requests, checked %0d results, %0d expected warnings.",
			requests_sent, results_seen, warn_seen);
		$display("Covered add, check, clear, unused action and four thresholds.");
		if (errors == 0 && expected_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
`default_nettype wire
